@@ sv/prtt_pkg.sv @@
`default_nettype none

package prtt_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] PERIOD_RST  = 16'd250;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // op codes
    localparam logic [2:0] OP_PING     = 3'd0;
    localparam logic [2:0] OP_PONG     = 3'd1;
    localparam logic [2:0] OP_PANG     = 3'd2;
    localparam logic [2:0] OP_FINISHED = 3'd3;
    localparam logic [2:0] OP_TICK     = 3'd4;

    // status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_OVERDUE  = 3'd3;
    localparam logic [2:0] ST_NOREPORT = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 1'b1;

    typedef struct packed {
        logic [15:0] method;
        logic [15:0] app;
        logic [31:0] serial;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic   keep;   // rotate head to tail of the occupied run
        logic   del;    // shift occupied run left, drop head
        logic   app;    // write wr at the first free cell
        t_entry wr;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] method;
        logic [15:0] app;
        logic [31:0] serial;
        logic [31:0] age;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

@@ sv/prtt_cell.sv @@
`default_nettype none

module prtt_cell #(
    parameter int DEPTH = prtt_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  wire logic                       i_clk,
    input  wire prtt_pkg::t_cell_ctl        i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_count,
    input  wire prtt_pkg::t_entry           i_next,
    output prtt_pkg::t_entry                o_ent
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] POS  = CW'(IDX);
    localparam logic [CW-1:0] POS1 = CW'(IDX + 1);

    prtt_pkg::t_entry r_ent;

    always_ff @(posedge i_clk) begin
        if ((i_ctl.keep || i_ctl.del) && (POS1 < i_count)) begin
            r_ent <= i_next;
        end else if (i_ctl.keep && (POS1 == i_count)) begin
            r_ent <= i_ctl.wr;
        end else if (i_ctl.app && (POS == i_count)) begin
            r_ent <= i_ctl.wr;
        end
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

@@ sv/pending_request_timeout_table.sv @@
// Outstanding request timeout table.
// Input channel (s): tuser carries the op, tdata the method, application and
// serial. Output channel (m): one or more result words per input word, tlast
// on the final one. Config port: write timeout_limit (index 0) or
// scan_period (index 1) while the block is idle.
// Entries sit in a row of cells; matching ops (pong, pang, finished) and
// scans rotate the occupied run past cell 0 one entry per cycle, except
// while a scan pauses: one pass over the N entries held, then a final step
// that waits for the output. Ping, unused ops and ticks without a scan are
// accepted back to back. A result is registered and holds in the output
// register until taken; the input is not accepted while that register is
// full and not being drained, and a scan pauses on a second overdue entry
// until the output frees up.
// Reset empties the table, clears the tick counter, stops the scan timer and
// reloads both registers with their defaults.
`default_nettype none

module pending_request_timeout_table #(
    parameter int DEPTH = prtt_pkg::DEPTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // method_id[15:0], app_id[31:16], serial[63:32]
    input  wire logic [prtt_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // op[2:0]
    input  wire logic [2:0]                      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // status[2:0], out_method[18:3], out_app[34:19], out_serial[66:35],
    // age[98:67], zero fill[103:99]
    output logic [prtt_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                 o_m_tlast,
    input  wire logic                            i_cfg_we,
    input  wire logic [prtt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [prtt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {S_IDLE, S_PASS} t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_rem, n_rem;
    logic              r_found, n_found;
    logic [31:0]       r_now, n_now;
    logic              r_run, n_run;
    logic [15:0]       r_phase, n_phase;
    logic [15:0]       r_tlim, n_tlim;
    logic [15:0]       r_per, n_per;
    logic              r_ov, n_ov;
    prtt_pkg::t_result r_out, n_out;
    logic              r_hv, n_hv;
    prtt_pkg::t_result r_hold, n_hold;
    logic [2:0]        r_op, n_op;
    logic [15:0]       r_m, n_m;
    logic [15:0]       r_a, n_a;
    logic [31:0]       r_s, n_s;

    prtt_pkg::t_cell_ctl w_ctl;
    prtt_pkg::t_entry    w_ent [DEPTH];
    prtt_pkg::t_entry    w_head;
    logic                w_out_free;
    logic                w_acc;
    logic                w_full;
    logic [31:0]         w_age;
    logic                w_over;
    logic [16:0]         w_ph1;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        prtt_pkg::t_entry w_nb;
        if (k < DEPTH - 1) begin : g_mid
            assign w_nb = w_ent[k+1];
        end else begin : g_end
            assign w_nb = w_ent[k];
        end
        prtt_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_cnt),
            .i_next  (w_nb),
            .o_ent   (w_ent[k])
        );
    end

    function automatic prtt_pkg::t_result plain_res(input logic [2:0] st);
        prtt_pkg::t_result res;
        res        = '0;
        res.status = st;
        res.last   = 1'b1;
        return res;
    endfunction

    assign w_head     = w_ent[0];
    assign w_out_free = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_full     = (r_cnt == CW'(DEPTH));
    assign w_age      = r_now - w_head.stamp;
    assign w_over     = w_age > {16'b0, r_tlim};
    assign w_ph1      = {1'b0, r_phase} + 17'd1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_found = r_found;
        n_now   = r_now;
        n_run   = r_run;
        n_phase = r_phase;
        n_tlim  = r_tlim;
        n_per   = r_per;
        n_ov    = r_ov && !i_m_tready;
        n_out   = r_out;
        n_hv    = r_hv;
        n_hold  = r_hold;
        n_op    = r_op;
        n_m     = r_m;
        n_a     = r_a;
        n_s     = r_s;
        w_ctl   = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                prtt_pkg::CFG_TIMEOUT: n_tlim = i_cfg_data;
                prtt_pkg::CFG_PERIOD:  n_per  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_op = i_s_tuser;
                    n_m  = i_s_tdata[15:0];
                    n_a  = i_s_tdata[31:16];
                    n_s  = i_s_tdata[63:32];
                    case (i_s_tuser)
                        prtt_pkg::OP_PING: begin
                            w_ctl.app = !w_full;
                            w_ctl.wr  = {i_s_tdata[15:0], i_s_tdata[31:16],
                                         i_s_tdata[63:32], r_now};
                            if (!w_full) begin
                                n_cnt = r_cnt + CW'(1);
                            end
                            if (!r_run) begin
                                n_run   = 1'b1;
                                n_phase = '0;
                            end
                            n_ov  = 1'b1;
                            n_out = plain_res(w_full ? prtt_pkg::ST_FULL
                                                     : prtt_pkg::ST_DONE);
                        end
                        prtt_pkg::OP_PONG, prtt_pkg::OP_PANG,
                        prtt_pkg::OP_FINISHED: begin
                            n_rem   = r_cnt;
                            n_found = 1'b0;
                            n_state = S_PASS;
                        end
                        prtt_pkg::OP_TICK: begin
                            n_now = r_now + 32'd1;
                            if (r_run && (w_ph1 >= {1'b0, r_per})) begin
                                n_phase = '0;
                                n_rem   = r_cnt;
                                n_hv    = 1'b0;
                                n_state = S_PASS;
                            end else begin
                                if (r_run) begin
                                    n_phase = w_ph1[15:0];
                                end
                                n_ov  = 1'b1;
                                n_out = plain_res(prtt_pkg::ST_NOREPORT);
                            end
                        end
                        default: begin
                            n_ov  = 1'b1;
                            n_out = plain_res(prtt_pkg::ST_DONE);
                        end
                    endcase
                end
            end

            S_PASS: begin
                if (r_rem == '0) begin
                    // wrap up: final word of this op
                    if (w_out_free) begin
                        n_state = S_IDLE;
                        n_ov    = 1'b1;
                        case (r_op)
                            prtt_pkg::OP_PONG: begin
                                n_out = plain_res(r_found ? prtt_pkg::ST_DONE
                                                          : prtt_pkg::ST_NOTFOUND);
                                if (r_found && (r_cnt == '0)) begin
                                    n_run = 1'b0;
                                end
                            end
                            prtt_pkg::OP_PANG: begin
                                if (!r_found) begin
                                    w_ctl.app = !w_full;
                                    w_ctl.wr  = {r_m, r_a, 32'd0, r_now};
                                    if (!w_full) begin
                                        n_cnt = r_cnt + CW'(1);
                                    end
                                    if (!r_run) begin
                                        n_run   = 1'b1;
                                        n_phase = '0;
                                    end
                                    n_out = plain_res(w_full ? prtt_pkg::ST_FULL
                                                             : prtt_pkg::ST_DONE);
                                end else begin
                                    n_out = plain_res(prtt_pkg::ST_DONE);
                                end
                            end
                            prtt_pkg::OP_TICK: begin
                                if (r_hv) begin
                                    n_out      = r_hold;
                                    n_out.last = 1'b1;
                                    n_hv       = 1'b0;
                                end else begin
                                    n_out = plain_res(prtt_pkg::ST_NOREPORT);
                                end
                            end
                            default: n_out = plain_res(prtt_pkg::ST_DONE);
                        endcase
                    end
                end else begin
                    n_rem = r_rem - CW'(1);
                    case (r_op)
                        prtt_pkg::OP_PONG: begin
                            if (!r_found && (w_head.method == r_m) &&
                                (w_head.app == r_a) && (w_head.serial == r_s)) begin
                                w_ctl.del = 1'b1;
                                n_cnt     = r_cnt - CW'(1);
                                n_found   = 1'b1;
                            end else begin
                                w_ctl.keep = 1'b1;
                                w_ctl.wr   = w_head;
                            end
                        end
                        prtt_pkg::OP_PANG: begin
                            w_ctl.keep = 1'b1;
                            w_ctl.wr   = w_head;
                            if (!r_found && (w_head.method == r_m) &&
                                (w_head.app == r_a) && (w_head.serial == 32'd0)) begin
                                w_ctl.wr.stamp = r_now;
                                n_found        = 1'b1;
                            end
                        end
                        prtt_pkg::OP_FINISHED: begin
                            if (w_head.app == r_a) begin
                                w_ctl.del = 1'b1;
                                n_cnt     = r_cnt - CW'(1);
                            end else begin
                                w_ctl.keep = 1'b1;
                                w_ctl.wr   = w_head;
                            end
                        end
                        default: begin
                            // scan: hold back one overdue word to mark the last
                            if (w_over && r_hv && !w_out_free) begin
                                n_rem = r_rem;
                            end else begin
                                w_ctl.keep = 1'b1;
                                w_ctl.wr   = w_head;
                                if (w_over) begin
                                    if (r_hv) begin
                                        n_ov  = 1'b1;
                                        n_out = r_hold;
                                    end
                                    n_hv   = 1'b1;
                                    n_hold = {prtt_pkg::ST_OVERDUE, w_head.method,
                                              w_head.app, w_head.serial, w_age, 1'b0};
                                end
                            end
                        end
                    endcase
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rem   <= '0;
            r_found <= 1'b0;
            r_now   <= '0;
            r_run   <= 1'b0;
            r_phase <= '0;
            r_tlim  <= prtt_pkg::TIMEOUT_RST;
            r_per   <= prtt_pkg::PERIOD_RST;
            r_ov    <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_found <= n_found;
            r_now   <= n_now;
            r_run   <= n_run;
            r_phase <= n_phase;
            r_tlim  <= n_tlim;
            r_per   <= n_per;
            r_ov    <= n_ov;
            r_hv    <= n_hv;
        end
        r_out  <= n_out;
        r_hold <= n_hold;
        r_op   <= n_op;
        r_m    <= n_m;
        r_a    <= n_a;
        r_s    <= n_s;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'b0, r_out.age, r_out.serial, r_out.app, r_out.method,
                         r_out.status};
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

@@ sv/prtt_chk.sv @@
`default_nettype none

module prtt_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [prtt_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                             o_m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tlast))
        else $error("stalled result word changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= prtt_pkg::ST_NOREPORT)
        else $error("status code out of range");

    // only overdue words carry entry fields
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != prtt_pkg::ST_OVERDUE) |->
        (o_m_tdata[prtt_pkg::OUT_TDATA_W-1:3] == '0))
        else $error("non-overdue word carries entry fields");

    // every status but overdue is the only word of its op
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[2:0] != prtt_pkg::ST_OVERDUE) |-> o_m_tlast)
        else $error("single-word result without tlast");

endmodule

bind pending_request_timeout_table prtt_chk u_prtt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
